>>> hw/rtl/rmt_pkg.sv
// Shared constants and types for the range match table.
package rmt_pkg;

  localparam int MAX_RANGES  = 16;
  localparam int TARGET_BITS = 8;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = $clog2(MAX_RANGES + 1);
  localparam int STAT_W      = 3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_RANGE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_OVERLAP   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

  // request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // classified request as it travels from the front end to the back end
  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key_low;
    logic signed [KEY_W-1:0] key_high;
    logic [TARGET_BITS-1:0]  target;
    logic                    bad_range;
  } rmt_item_t;

endpackage

>>> hw/rtl/range_match_table_core.sv
// Range match table top level: front end, request queue and scanning back end.
// Flow: a request is written into the queue, popped by the back end, compared against
//   the stored ranges in turn until a hit (up to 16), then loaded into the result register.
// The back end's single range comparator steps through the table, so it takes a new request
//   only after the last one is in the result register; the queue holds the waiting ones.
// Reset clears the queue, the range count and the result valid; table contents stay.
module range_match_table_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic signed [31:0]         in_key_low,
  input  logic signed [31:0]         in_key_high,
  input  logic [7:0]                 in_target_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [7:0]                 out_target_out,
  output logic [3:0]                 out_match_index
);
  import rmt_pkg::*;

  logic      q_valid;
  logic      q_pop;
  rmt_item_t q_item;

  rmt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_key_low   (in_key_low),
    .in_key_high  (in_key_high),
    .in_target_in (in_target_in),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  rmt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_target_out  (out_target_out),
    .out_match_index (out_match_index)
  );

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // any non-ok result carries zero target and index
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_target_out == '0 && out_match_index == '0))
    else $error("failed request returned target or index");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= STAT_FULL))
    else $error("undefined status code");

endmodule

>>> hw/rtl/rmt_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module rmt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic signed [31:0]          in_key_low,
  input  logic signed [31:0]          in_key_high,
  input  logic [7:0]                  in_target_in,
  output logic                        q_valid,
  output rmt_pkg::rmt_item_t          q_item,
  input  logic                        q_pop
);
  import rmt_pkg::*;

  localparam int QDEPTH = 2;

  rmt_item_t  q_mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  rmt_item_t  item_new;

  // classify: an insert with bottom above top is rejected without a scan
  always_comb begin
    item_new.mode      = in_mode;
    item_new.key_low   = in_key_low;
    item_new.key_high  = in_key_high;
    item_new.target    = in_target_in[TARGET_BITS-1:0];
    item_new.bad_range = (in_mode == MODE_INSERT) && (in_key_low > in_key_high);
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_new;
    end
  end

endmodule

>>> hw/rtl/rmt_back.sv
// Back end: range table, sequential scan and result register.
module rmt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rmt_pkg::rmt_item_t            q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rmt_pkg::STAT_W-1:0]    out_status,
  output logic [7:0]                    out_target_out,
  output logic [rmt_pkg::IDX_W-1:0]     out_match_index
);
  import rmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  // range table, contents undefined until written
  logic signed [KEY_W-1:0] tbl_bottom_r [MAX_RANGES];
  logic signed [KEY_W-1:0] tbl_top_r    [MAX_RANGES];
  logic [TARGET_BITS-1:0]  tbl_target_r [MAX_RANGES];

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  rmt_item_t              cur_r, cur_nxt;
  rmt_item_t              eff_item;
  logic [STAT_W-1:0]      res_status_r, res_status_nxt;
  logic [TARGET_BITS-1:0] res_target_r, res_target_nxt;
  logic [IDX_W-1:0]       res_index_r, res_index_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [TARGET_BITS-1:0] out_target_r, out_target_nxt;
  logic [IDX_W-1:0]       out_index_r, out_index_nxt;
  logic                   tbl_we;
  logic signed [KEY_W-1:0] ent_bottom, ent_top;
  logic                   hit_lookup, hit_overlap, hit;
  logic                   last_entry;

  // current table entry under the scan pointer
  assign ent_bottom = tbl_bottom_r[idx_r];
  assign ent_top    = tbl_top_r[idx_r];

  assign hit_lookup  = (ent_bottom <= cur_r.key_low) && (ent_top >= cur_r.key_low);
  assign hit_overlap = ((cur_r.key_low  >= ent_bottom) && (cur_r.key_low  <= ent_top)) ||
                       ((cur_r.key_high >= ent_bottom) && (cur_r.key_high <= ent_top)) ||
                       ((cur_r.key_low  <= ent_bottom) && (cur_r.key_high >= ent_top));
  assign hit         = (cur_r.mode == MODE_LOOKUP) ? hit_lookup : hit_overlap;
  assign last_entry  = ({1'b0, idx_r} == (count_r - CNT_W'(1)));

  // request being finished: straight from the queue when no scan is needed
  assign eff_item = (state_r == S_IDLE) ? q_item : cur_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_target_nxt = res_target_r;
    res_index_nxt  = res_index_r;
    q_pop          = 1'b0;
    tbl_we         = 1'b0;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_target_nxt = out_target_r;
    out_index_nxt  = out_index_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          idx_nxt = '0;
          if (q_item.bad_range) begin
            res_status_nxt = STAT_BAD_RANGE;
            res_target_nxt = '0;
            res_index_nxt  = '0;
            state_nxt      = S_RESP;
          end else if (count_r == '0) begin
            state_nxt = S_RESP;
            res_target_nxt = '0;
            res_index_nxt  = '0;
            if (q_item.mode == MODE_LOOKUP) begin
              res_status_nxt = STAT_NOT_FOUND;
            end else begin
              res_status_nxt = STAT_OK;
              tbl_we         = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_RESP;
          if (cur_r.mode == MODE_LOOKUP) begin
            res_status_nxt = STAT_OK;
            res_target_nxt = tbl_target_r[idx_r];
            res_index_nxt  = idx_r;
          end else begin
            res_status_nxt = STAT_OVERLAP;
            res_target_nxt = '0;
            res_index_nxt  = '0;
          end
        end else if (last_entry) begin
          state_nxt      = S_RESP;
          res_target_nxt = '0;
          res_index_nxt  = '0;
          if (cur_r.mode == MODE_LOOKUP) begin
            res_status_nxt = STAT_NOT_FOUND;
          end else if (count_r >= CNT_W'(MAX_RANGES)) begin
            res_status_nxt = STAT_FULL;
          end else begin
            res_status_nxt = STAT_OK;
            res_index_nxt  = count_r[IDX_W-1:0];
            tbl_we         = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_target_nxt = res_target_r;
          out_index_nxt  = res_index_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_target_r <= res_target_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_target_r <= out_target_nxt;
    out_index_r  <= out_index_nxt;
  end

  // append at the next free slot
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_bottom_r[count_r[IDX_W-1:0]] <= eff_item.key_low;
      tbl_top_r[count_r[IDX_W-1:0]]    <= eff_item.key_high;
      tbl_target_r[count_r[IDX_W-1:0]] <= eff_item.target;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_target_out  = out_target_r;
  assign out_match_index = out_index_r;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the range match table: directed and random requests.
`timescale 1ns / 100ps

module testbench;
  import rmt_pkg::*;

  // one request as the driver offers it; drain holds it back until all results are in
  typedef struct {
    logic               mode;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [7:0]         tgt;
    bit                 drain;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] target;
    logic [3:0] index;
  } rsp_t;

  localparam int NUM_RANDOM  = 800;
  localparam int NUM_CENTERS = 14;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = MODE_INSERT;
  logic signed [31:0] in_key_low = '0;
  logic signed [31:0] in_key_high = '0;
  logic [7:0]         in_target_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [7:0]         out_target_out;
  logic [3:0]         out_match_index;

  // shadow copy of the range table
  logic signed [31:0] shadow_bottom [MAX_RANGES];
  logic signed [31:0] shadow_top    [MAX_RANGES];
  logic [7:0]         shadow_target [MAX_RANGES];
  int                 shadow_count = 0;

  req_t pending_reqs[$];
  rsp_t expected_results[$];
  logic signed [31:0] key_centers [NUM_CENTERS];

  int n_err = 0;
  int n_sent = 0;
  int n_recv = 0;
  int burst_left = 4;
  int gap_left = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  bit long_hold_done = 1'b0;
  logic rx_hold = 1'b0;

  range_match_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_key_low      (in_key_low),
    .in_key_high     (in_key_high),
    .in_target_in    (in_target_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_target_out  (out_target_out),
    .out_match_index (out_match_index)
  );

  always #1 clk = ~clk;

  // expected response of one request; inserts update the shadow table
  function automatic rsp_t apply_request(req_t r);
    rsp_t p;
    bit   hit;
    p.status = STAT_OK;
    p.target = '0;
    p.index  = '0;
    hit      = 1'b0;
    if (r.mode == MODE_LOOKUP) begin
      p.status = STAT_NOT_FOUND;
      for (int i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_bottom[i] <= r.lo && shadow_top[i] >= r.lo) begin
          hit      = 1'b1;
          p.status = STAT_OK;
          p.target = shadow_target[i];
          p.index  = 4'(i);
        end
      end
    end else if (r.lo > r.hi) begin
      p.status = STAT_BAD_RANGE;
    end else begin
      for (int i = 0; i < shadow_count; i++) begin
        if ((r.lo >= shadow_bottom[i] && r.lo <= shadow_top[i]) ||
            (r.hi >= shadow_bottom[i] && r.hi <= shadow_top[i]) ||
            (r.lo <= shadow_bottom[i] && r.hi >= shadow_top[i]))
          hit = 1'b1;
      end
      if (hit) begin
        p.status = STAT_OVERLAP;
      end else if (shadow_count >= MAX_RANGES) begin
        p.status = STAT_FULL;
      end else begin
        shadow_bottom[shadow_count] = r.lo;
        shadow_top[shadow_count]    = r.hi;
        shadow_target[shadow_count] = r.tgt;
        p.index = 4'(shadow_count);
        shadow_count++;
      end
    end
    return p;
  endfunction

  function automatic logic signed [31:0] clamp_key(longint k);
    if (k > 64'sd2147483647) return 32'sh7fff_ffff;
    if (k < -64'sd2147483648) return 32'sh8000_0000;
    return k[31:0];
  endfunction

  // keys cluster around a few centers so ranges collide and lookups hit
  function automatic logic signed [31:0] pick_key();
    int     sel;
    longint k;
    sel = $urandom_range(0, 7);
    if (sel < 2) return $urandom;
    if (sel == 2) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    k = longint'(key_centers[$urandom_range(0, NUM_CENTERS - 1)]) +
        longint'($urandom_range(0, 40)) - 64'sd20;
    return clamp_key(k);
  endfunction

  task automatic add_req(logic mode, logic signed [31:0] lo, logic signed [31:0] hi,
                         logic [7:0] tgt, bit drain);
    req_t r;
    r.mode  = mode;
    r.lo    = lo;
    r.hi    = hi;
    r.tgt   = tgt;
    r.drain = drain;
    pending_reqs = {pending_reqs, r};
  endtask

  // stimulus: directed corner cases, then random traffic
  initial begin
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             w;
    key_centers[0] = 32'sh8000_0000;
    key_centers[1] = 32'sh7fff_ffff;
    key_centers[2] = 32'sh0000_0000;
    for (int i = 3; i < NUM_CENTERS; i++) key_centers[i] = $urandom;

    // empty table, then bad ranges and ranges at the key extremes
    add_req(MODE_LOOKUP, 32'sd0, 32'sh7fff_ffff, 8'h00, 1'b0);
    add_req(MODE_LOOKUP, 32'sh8000_0000, 32'sd0, 8'hff, 1'b0);
    add_req(MODE_INSERT, 32'sd5, 32'sd4, 8'h11, 1'b0);
    add_req(MODE_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 8'h22, 1'b0);
    add_req(MODE_INSERT, 32'sh8000_0000, 32'sh8000_0009, 8'hff, 1'b0);
    add_req(MODE_INSERT, 32'sh7fff_fff6, 32'sh7fff_ffff, 8'h00, 1'b0);
    add_req(MODE_INSERT, 32'sd100, 32'sd100, 8'ha5, 1'b0);
    // overlap by top, by bottom, by covering; bad range checked ahead of overlap
    add_req(MODE_INSERT, 32'sd90, 32'sd100, 8'h33, 1'b0);
    add_req(MODE_INSERT, 32'sd100, 32'sd110, 8'h44, 1'b0);
    add_req(MODE_INSERT, 32'sd50, 32'sd200, 8'h55, 1'b0);
    add_req(MODE_INSERT, 32'sd100, 32'sd99, 8'h66, 1'b0);
    add_req(MODE_INSERT, -32'sd1000, -32'sd1, 8'h5a, 1'b0);
    add_req(MODE_INSERT, 32'sh8000_0000, 32'sh7fff_ffff, 8'h77, 1'b0);
    // lookups on hits, edges and misses
    add_req(MODE_LOOKUP, 32'sh8000_0000, 32'shffff_ffff, 8'h00, 1'b0);
    add_req(MODE_LOOKUP, 32'sh7fff_ffff, 32'sh8000_0000, 8'hff, 1'b0);
    add_req(MODE_LOOKUP, 32'sd100, 32'sd0, 8'h00, 1'b0);
    add_req(MODE_LOOKUP, 32'sd101, 32'sd0, 8'h00, 1'b0);
    add_req(MODE_LOOKUP, -32'sd1, 32'sh8000_0000, 8'h00, 1'b0);
    add_req(MODE_LOOKUP, -32'sd1001, 32'sh7fff_ffff, 8'h00, 1'b0);
    add_req(MODE_LOOKUP, 32'sd0, 32'shffff_ffff, 8'hff, 1'b0);

    // random mix; the table fills early, after which inserts see full or overlap
    for (int n = 0; n < NUM_RANDOM; n++) begin
      lo = pick_key();
      if ($urandom_range(0, 99) < 35) begin
        case ($urandom_range(0, 8))
          0, 1:    w = 0;
          2, 3, 4: w = $urandom_range(1, 30);
          5, 6:    w = $urandom_range(0, 5000);
          7:       w = -1;
          default: w = -longint'($urandom_range(1, 100));
        endcase
        if (w == -1) hi = $urandom;
        else hi = clamp_key(longint'(lo) + w);
        add_req(MODE_INSERT, lo, hi, 8'($urandom_range(0, 255)), n == 0 || n == 400);
      end else begin
        add_req(MODE_LOOKUP, lo, $urandom, 8'($urandom_range(0, 255)), n == 0 || n == 400);
      end
    end
  end

  // reset
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request driver: bursts with random gaps, keeps offering while the receiver holds
  always @(posedge clk) begin : req_driver
    logic next_valid;
    req_t taken;
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        taken.mode  = in_mode;
        taken.lo    = in_key_low;
        taken.hi    = in_key_high;
        taken.tgt   = in_target_in;
        taken.drain = 1'b0;
        expected_results = {expected_results, apply_request(taken)};
        n_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0 && !rx_hold) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && n_sent != n_recv)) begin
          nxt = pending_reqs.pop_front();
          in_mode      <= nxt.mode;
          in_key_low   <= nxt.lo;
          in_key_high  <= nxt.hi;
          in_target_in <= nxt.tgt;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // response monitor: checks in order, stalls on a rotating pattern plus one long hold
  always @(posedge clk) begin : rsp_monitor
    rsp_t got;
    rsp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_status, out_target_out, out_match_index};
        if (expected_results.size() == 0) begin
          n_err++;
          $display("%0t unexpected response: status %0d target %0d index %0d",
                   $time, got.status, got.target, got.index);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            n_err++;
            $display("%0t mismatch: expected status %0d target %0d index %0d, actual %0d %0d %0d",
                     $time, want.status, want.target, want.index,
                     got.status, got.target, got.index);
          end
        end
        n_recv <= n_recv + 1;
      end
      rx_cycle++;
      if (hold_left == 0 && !long_hold_done && n_recv >= 120) begin
        hold_left      = 600;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 128) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((rx_cycle % 7) < 3);
        endcase
      end
      rx_hold <= (hold_left > 0);
    end
  end

  // end of run: everything sent and answered, then let the pipeline settle
  initial begin
    @(posedge rst_n);
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
    if (n_err == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
